### rtl/core/crflp_pkg.sv
package crflp_pkg;

   localparam int NUM_LABELS_DEFAULT = 32;
   localparam int LABEL_W = 5;
   localparam int SCORE_W = 32;

   // softplus table: ln(1 + e^(-k/4)) in q16.16, k = d >> LUT_SHIFT
   localparam int LUT_SHIFT = 14;
   localparam int LUT_BITS = 5;
   localparam int LUT_SIZE = 32;

   typedef logic [LABEL_W-1:0] label_type;
   typedef logic signed [SCORE_W-1:0] score_type;

   localparam score_type Q_MAX = 32'sh7FFF_FFFF;
   localparam score_type Q_MIN = 32'sh8000_0000;

   localparam logic CMD_TRANS = 1'b0;
   localparam logic CMD_EMIT = 1'b1;

   localparam logic [15:0] SOFTPLUS_LUT [LUT_SIZE] = '{
      16'd45426, 16'd37745, 16'd31069, 16'd25354, 16'd20530, 16'd16510, 16'd13200, 16'd10500,
      16'd8318, 16'd6567, 16'd5170, 16'd4061, 16'd3184, 16'd2493, 16'd1950, 16'd1523,
      16'd1189, 16'd928, 16'd724, 16'd565, 16'd440, 16'd343, 16'd267, 16'd208,
      16'd162, 16'd126, 16'd98, 16'd77, 16'd60, 16'd47, 16'd36, 16'd28
   };

   typedef struct packed {
      logic      command;
      label_type to_label;
      label_type from_label;
      score_type value;
      logic      first_frame;
      logic      last_frame;
   } req_type;

   typedef struct packed {
      label_type label;
      score_type forward_score;
      label_type best_prev;
      score_type total_score;
      logic      total_valid;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FOLD,
      ST_SCORE,
      ST_UPDATE,
      ST_COPY
   } state_type;

   // exact sum, saturated to the signed 32-bit range
   function automatic score_type sat_add(input score_type a, input score_type b);
      logic signed [SCORE_W:0] s;
      s = {a[SCORE_W-1], a} + {b[SCORE_W-1], b};
      if (s[SCORE_W] != s[SCORE_W-1]) begin
         sat_add = s[SCORE_W] ? Q_MIN : Q_MAX;
      end else begin
         sat_add = s[SCORE_W-1:0];
      end
   endfunction

endpackage

### rtl/core/crflp_ram.sv
module crflp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### rtl/core/crflp_lse.sv
module crflp_lse (
   input  crflp_pkg::score_type a,
   input  crflp_pkg::score_type b,
   output crflp_pkg::score_type y
);

   localparam int W = crflp_pkg::SCORE_W;
   localparam int TOP = crflp_pkg::LUT_SHIFT + crflp_pkg::LUT_BITS;

   crflp_pkg::score_type hi;
   crflp_pkg::score_type lo;
   logic [W:0] diff;
   logic [15:0] corr;
   logic signed [W:0] sum;

   always_comb begin
      if (a > b) begin
         hi = a;
         lo = b;
      end else begin
         hi = b;
         lo = a;
      end
      // difference is never negative, so 33 bits hold it unsigned
      diff = {hi[W-1], hi} - {lo[W-1], lo};
      if (diff[W:TOP] == '0) begin
         corr = crflp_pkg::SOFTPLUS_LUT[diff[TOP-1:crflp_pkg::LUT_SHIFT]];
      end else begin
         corr = '0;
      end
      sum = {hi[W-1], hi} + {{(W+1-16){1'b0}}, corr};
      // correction is positive: only the upper bound can be crossed
      if (sum[W] != sum[W-1]) begin
         y = crflp_pkg::Q_MAX;
      end else begin
         y = sum[W-1:0];
      end
   end

endmodule

### rtl/core/crf_forward_log_partition_unit.sv
// crf forward pass in the log domain, signed q16.16 with saturation. a req_ transfer with
// command 0 writes one transition weight (to_label, from_label); it leaves the unit idle
// and gives no rsp_ transfer. a transfer with command 1 gives one emission score; emissions
// come frame by frame in label order and each yields one rsp_ transfer with the new forward
// score, the best predecessor and, on the last label of a last frame, the log partition.
// a first-frame emission passes through the score and update states before req_ready is
// back. a later-frame emission first walks the whole transition row and the previous frame
// through one shared log-sum-exp unit, one predecessor per cycle, before score and update.
// after the last label of each frame the current scores are copied into the previous-score
// memory, one entry per cycle, while req_ready stays low. a response that has not been
// taken holds the next one back, and req_ready stays low until it goes. labels at or above
// NUM_LABELS are dropped without a response. transitions and scores that were never written
// read back as garbage.
module crf_forward_log_partition_unit #(
   parameter int NUM_LABELS = crflp_pkg::NUM_LABELS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  crflp_pkg::req_type req_payload,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output crflp_pkg::rsp_type rsp_payload
);

   localparam int LW = $clog2(NUM_LABELS);
   localparam int TAW = $clog2(NUM_LABELS * NUM_LABELS);
   localparam int CW = $clog2(NUM_LABELS + 2);

   // control state
   crflp_pkg::state_type state_ff, state_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   crflp_pkg::score_type total_ff, total_in;

   // item and datapath registers
   crflp_pkg::label_type label_ff, label_in;
   crflp_pkg::score_type value_ff, value_in;
   logic                 first_ff, first_in;
   logic                 last_ff, last_in;
   logic [TAW-1:0]       row_base_ff, row_base_in;
   crflp_pkg::score_type z_ff, z_in;
   crflp_pkg::score_type acc_ff, acc_in;
   crflp_pkg::score_type top_ff, top_in;
   logic [LW-1:0]        best_ff, best_in;
   crflp_pkg::score_type score_ff, score_in;
   crflp_pkg::rsp_type   rsp_ff, rsp_in;

   // memory ports
   logic                 trans_wr_en;
   logic [TAW-1:0]       trans_wr_addr;
   logic [TAW-1:0]       trans_rd_addr;
   crflp_pkg::score_type trans_rd_data;
   logic                 prev_wr_en;
   logic [LW-1:0]        prev_wr_addr;
   logic [LW-1:0]        prev_rd_addr;
   crflp_pkg::score_type prev_rd_data;
   logic                 cur_wr_en;
   logic [LW-1:0]        cur_rd_addr;
   crflp_pkg::score_type cur_rd_data;

   // shared log-sum-exp unit
   crflp_pkg::score_type lse_a, lse_b, lse_y;

   logic          to_ok, from_ok, label_is_last, out_free;
   logic [LW-1:0] fold_idx;
   crflp_pkg::score_type new_total;

   crflp_ram #(
      .WIDTH(crflp_pkg::SCORE_W),
      .DEPTH(NUM_LABELS * NUM_LABELS)
   ) u_trans_ram (
      .clock  (clock),
      .wr_en  (trans_wr_en),
      .wr_addr(trans_wr_addr),
      .wr_data(req_payload.value),
      .rd_addr(trans_rd_addr),
      .rd_data(trans_rd_data)
   );

   // previous-frame scores, read during the fold, filled by the copy sweep
   crflp_ram #(
      .WIDTH(crflp_pkg::SCORE_W),
      .DEPTH(NUM_LABELS)
   ) u_prev_ram (
      .clock  (clock),
      .wr_en  (prev_wr_en),
      .wr_addr(prev_wr_addr),
      .wr_data(cur_rd_data),
      .rd_addr(prev_rd_addr),
      .rd_data(prev_rd_data)
   );

   // current-frame scores, written once per emission
   crflp_ram #(
      .WIDTH(crflp_pkg::SCORE_W),
      .DEPTH(NUM_LABELS)
   ) u_cur_ram (
      .clock  (clock),
      .wr_en  (cur_wr_en),
      .wr_addr(LW'(label_ff)),
      .wr_data(score_ff),
      .rd_addr(cur_rd_addr),
      .rd_data(cur_rd_data)
   );

   crflp_lse u_lse (
      .a(lse_a),
      .b(lse_b),
      .y(lse_y)
   );

   assign to_ok = int'(req_payload.to_label) < NUM_LABELS;
   assign from_ok = int'(req_payload.from_label) < NUM_LABELS;
   assign label_is_last = int'(label_ff) == NUM_LABELS - 1;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // fold index trails the issued read address by the ram latency and the z register
   assign fold_idx = LW'(cnt_ff - CW'(2));

   assign trans_wr_addr = TAW'(int'(req_payload.to_label) * NUM_LABELS
                               + int'(req_payload.from_label));
   assign trans_rd_addr = row_base_ff + TAW'(cnt_ff[LW-1:0]);
   assign prev_rd_addr = cnt_ff[LW-1:0];
   assign cur_rd_addr = cnt_ff[LW-1:0];
   assign prev_wr_addr = LW'(cnt_ff - CW'(1));

   // z of the predecessor whose row and previous score just came out of the rams
   assign z_in = crflp_pkg::sat_add(trans_rd_data, prev_rd_data);

   assign req_ready = state_ff == crflp_pkg::ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= crflp_pkg::ST_IDLE;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
         total_ff <= crflp_pkg::Q_MIN;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      label_ff <= label_in;
      value_ff <= value_in;
      first_ff <= first_in;
      last_ff <= last_in;
      row_base_ff <= row_base_in;
      z_ff <= z_in;
      acc_ff <= acc_in;
      top_ff <= top_in;
      best_ff <= best_in;
      score_ff <= score_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      total_in = total_ff;
      label_in = label_ff;
      value_in = value_ff;
      first_in = first_ff;
      last_in = last_ff;
      row_base_in = row_base_ff;
      acc_in = acc_ff;
      top_in = top_ff;
      best_in = best_ff;
      score_in = score_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      trans_wr_en = 1'b0;
      prev_wr_en = 1'b0;
      cur_wr_en = 1'b0;
      lse_a = acc_ff;
      lse_b = z_ff;
      new_total = total_ff;

      unique case (state_ff)
         crflp_pkg::ST_IDLE: begin
            if (req_valid && to_ok) begin
               if (req_payload.command == crflp_pkg::CMD_TRANS) begin
                  trans_wr_en = from_ok;
               end else begin
                  label_in = req_payload.to_label;
                  value_in = req_payload.value;
                  first_in = req_payload.first_frame;
                  last_in = req_payload.last_frame;
                  row_base_in = TAW'(int'(req_payload.to_label) * NUM_LABELS);
                  cnt_in = '0;
                  state_in = req_payload.first_frame ? crflp_pkg::ST_SCORE
                                                     : crflp_pkg::ST_FOLD;
               end
            end
         end

         crflp_pkg::ST_FOLD: begin
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff >= CW'(2)) begin
               if (fold_idx == '0) begin
                  acc_in = z_ff;
                  top_in = z_ff;
                  best_in = '0;
               end else begin
                  acc_in = lse_y;
                  // strict compare keeps the lowest index on ties
                  if (top_ff < z_ff) begin
                     top_in = z_ff;
                     best_in = fold_idx;
                  end
               end
            end
            if (int'(cnt_ff) == NUM_LABELS + 1) begin
               state_in = crflp_pkg::ST_SCORE;
            end
         end

         crflp_pkg::ST_SCORE: begin
            score_in = first_ff ? value_ff : crflp_pkg::sat_add(acc_ff, value_ff);
            state_in = crflp_pkg::ST_UPDATE;
         end

         crflp_pkg::ST_UPDATE: begin
            lse_a = total_ff;
            lse_b = score_ff;
            new_total = (label_ff == '0) ? score_ff : lse_y;
            if (out_free) begin
               cur_wr_en = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_in.label = label_ff;
               rsp_in.forward_score = score_ff;
               rsp_in.best_prev = first_ff ? '0 : crflp_pkg::label_type'(best_ff);
               rsp_in.total_score = '0;
               rsp_in.total_valid = 1'b0;
               if (last_ff) begin
                  total_in = new_total;
                  if (label_is_last) begin
                     rsp_in.total_score = new_total;
                     rsp_in.total_valid = 1'b1;
                     total_in = crflp_pkg::Q_MIN;
                  end
               end
               cnt_in = '0;
               state_in = label_is_last ? crflp_pkg::ST_COPY : crflp_pkg::ST_IDLE;
            end
         end

         crflp_pkg::ST_COPY: begin
            // read current[cnt], write previous[cnt-1] with last cycle's read
            cnt_in = cnt_ff + CW'(1);
            prev_wr_en = cnt_ff != '0;
            if (int'(cnt_ff) == NUM_LABELS) begin
               state_in = crflp_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = crflp_pkg::ST_IDLE;
         end
      endcase
   end

endmodule
